### sv/smms_pkg.sv
// smms_pkg: shared types and constants for the stack with min/max and search
// no dependencies; imported by every module of the block
package smms_pkg;

  localparam int DEPTH = 16;
  localparam int DATA_W = 32;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);
  localparam int ROW_W = 3 * DATA_W;

  localparam logic [1:0] MODE_PUSH = 2'd0;
  localparam logic [1:0] MODE_POP = 2'd1;
  localparam logic [1:0] MODE_SEARCH = 2'd2;

  localparam logic [1:0] STAT_OK = 2'd0;
  localparam logic [1:0] STAT_FULL = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0] mode;
    logic signed [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [CNT_W-1:0] entry_count;
    logic is_empty;
    logic signed [DATA_W-1:0] min_value;
    logic signed [DATA_W-1:0] max_value;
    logic found;
    logic [IDX_W-1:0] match_index;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic push;
    logic pop;
    logic minmax_ld;
    logic rd_en;
    logic rd_pop;
    logic rd_next;
    logic idx_clr;
    logic idx_inc;
    logic hit_ld;
    logic status_we;
    logic [1:0] status;
  } smms_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] mode;
    logic full;
    logic empty;
    logic one_left;
    logic hit;
    logic last;
  } smms_stat_t;

endpackage

### sv/smms_ctrl.sv
// smms_ctrl: sequencing state machine for push, pop and search transactions
// depends on smms_pkg for command and status structs and the mode codes
module smms_ctrl
  import smms_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  output logic       out_valid,
  input  smms_stat_t st,
  output smms_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC = 3'd1;
  localparam logic [2:0] S_POPW = 3'd2;
  localparam logic [2:0] S_SRCH = 3'd3;
  localparam logic [2:0] S_OUT = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        state_nxt = S_OUT;
        case (st.mode)
          MODE_PUSH: begin
            if (st.full) begin
              cmd.status_we = 1'b1;
              cmd.status = STAT_FULL;
            end else begin
              cmd.push = 1'b1;
            end
          end
          MODE_POP: begin
            if (st.empty) begin
              cmd.status_we = 1'b1;
              cmd.status = STAT_EMPTY;
            end else begin
              cmd.pop = 1'b1;
              // fetch min/max recorded for the new top entry
              if (!st.one_left) begin
                cmd.rd_en = 1'b1;
                cmd.rd_pop = 1'b1;
                state_nxt = S_POPW;
              end
            end
          end
          MODE_SEARCH: begin
            if (!st.empty) begin
              cmd.rd_en = 1'b1;
              cmd.idx_clr = 1'b1;
              state_nxt = S_SRCH;
            end
          end
          default: begin
            state_nxt = S_OUT;
          end
        endcase
      end
      S_POPW: begin
        cmd.minmax_ld = 1'b1;
        state_nxt = S_OUT;
      end
      S_SRCH: begin
        if (st.hit) begin
          cmd.hit_ld = 1'b1;
          state_nxt = S_OUT;
        end else if (st.last) begin
          state_nxt = S_OUT;
        end else begin
          cmd.rd_en = 1'b1;
          cmd.rd_next = 1'b1;
          cmd.idx_inc = 1'b1;
        end
      end
      S_OUT: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

### sv/smms_dp.sv
// smms_dp: entry memory with per-level min/max, fill counter and search compare
// depends on smms_pkg; driven by smms_ctrl through smms_cmd_t
module smms_dp
  import smms_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  in_item_t   in_item,
  input  smms_cmd_t  cmd,
  output smms_stat_t st,
  output out_item_t  out_item
);

  // each row holds the entry and the min/max of all entries up to it
  logic [ROW_W-1:0] mem [DEPTH];
  logic [ROW_W-1:0] rd_data_r;
  logic [IDX_W-1:0] rd_addr;

  logic [CNT_W-1:0] fill_r;
  logic [CNT_W-1:0] fill_nxt;
  logic [1:0] mode_r;
  logic signed [DATA_W-1:0] value_r;
  logic signed [DATA_W-1:0] min_r;
  logic signed [DATA_W-1:0] max_r;
  logic [1:0] status_r;
  logic found_r;
  logic [IDX_W-1:0] match_r;
  logic [IDX_W-1:0] idx_r;

  logic signed [DATA_W-1:0] rd_entry;
  logic signed [DATA_W-1:0] rd_min;
  logic signed [DATA_W-1:0] rd_max;
  logic signed [DATA_W-1:0] new_min;
  logic signed [DATA_W-1:0] new_max;
  logic [CNT_W-1:0] fill_m2;

  assign rd_entry = rd_data_r[ROW_W-1 -: DATA_W];
  assign rd_min = rd_data_r[2*DATA_W-1 -: DATA_W];
  assign rd_max = rd_data_r[DATA_W-1:0];

  assign st.mode = mode_r;
  assign st.full = (fill_r == CNT_W'(DEPTH));
  assign st.empty = (fill_r == '0);
  assign st.one_left = (fill_r == CNT_W'(1));
  assign st.hit = (rd_entry == value_r);
  assign st.last = (({1'b0, idx_r} + CNT_W'(1)) == fill_r);

  assign fill_m2 = fill_r - CNT_W'(2);

  always_comb begin
    if (cmd.rd_pop) begin
      rd_addr = fill_m2[IDX_W-1:0];
    end else if (cmd.rd_next) begin
      rd_addr = idx_r + IDX_W'(1);
    end else begin
      rd_addr = '0;
    end
  end

  always_comb begin
    if (fill_r == '0) begin
      new_min = value_r;
      new_max = value_r;
    end else begin
      new_min = (value_r < min_r) ? value_r : min_r;
      new_max = (value_r > max_r) ? value_r : max_r;
    end
  end

  always_comb begin
    fill_nxt = fill_r;
    if (cmd.push) begin
      fill_nxt = fill_r + CNT_W'(1);
    end else if (cmd.pop) begin
      fill_nxt = fill_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[fill_r[IDX_W-1:0]] <= {value_r, new_min, new_max};
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_item.mode;
      value_r <= in_item.value;
      status_r <= STAT_OK;
      found_r <= 1'b0;
      match_r <= '0;
    end
    if (cmd.status_we) begin
      status_r <= cmd.status;
    end
    if (cmd.hit_ld) begin
      found_r <= 1'b1;
      match_r <= idx_r;
    end
    if (cmd.push) begin
      min_r <= new_min;
      max_r <= new_max;
    end
    if (cmd.minmax_ld) begin
      min_r <= rd_min;
      max_r <= rd_max;
    end
    if (cmd.idx_clr) begin
      idx_r <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + IDX_W'(1);
    end
  end

  always_comb begin
    out_item.status = status_r;
    out_item.entry_count = fill_r;
    out_item.is_empty = (fill_r == '0);
    out_item.min_value = (fill_r == '0) ? '0 : min_r;
    out_item.max_value = (fill_r == '0) ? '0 : max_r;
    out_item.found = found_r;
    out_item.match_index = match_r;
  end

endmodule

### sv/stack_with_min_max_search_top.sv
// stack_with_min_max_search_top: bounded stack of signed values with min, max and search
// depends on smms_pkg, smms_ctrl and smms_dp
//
// usage:
//   input channel: in_item (mode, value) is taken at a rising edge where start
//   is high and busy is low. busy stays high until the result has been shown.
//   result channel: out_item is valid for exactly one cycle while out_valid is
//   high; the receiver has no way to hold it off and must take it then.
//   every transaction yields exactly one result.
// steps from the accept edge to the result:
//   push, refused pop, pop to empty, mode 3, search of empty stack: decode, then result
//   pop that leaves entries: decode, one read of the stored min/max row, then result
//   search: decode, then one memory read and compare per entry, up to the oldest
//   match or the whole fill level, then result
// busy drops the cycle after the result, so the next transaction can start in the
// cycle after out_valid; items are handled one at a time.
// the single-port entry memory, read once per cycle, sets the search time.
// reset (rst_n low, synchronous) empties the stack and returns to idle; the
// entry memory keeps its contents, which are only read below the fill level.
module stack_with_min_max_search_top
  import smms_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  smms_cmd_t  cmd;
  smms_stat_t st;

  smms_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .st        (st),
    .cmd       (cmd)
  );

  smms_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cmd      (cmd),
    .st       (st),
    .out_item (out_item)
  );

endmodule

### sv/smms_checker.sv
// smms_checker: port-level checks on the stack block, bound to the top level
// depends on smms_pkg and stack_with_min_max_search_top
module smms_checker
  import smms_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_valid,
  input out_item_t out_item
);

  // an accepted transaction holds the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after accept");

  // one result strobe per transaction
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.is_empty == (out_item.entry_count == '0)))
    else $error("empty flag disagrees with count");

  a_empty_minmax: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.is_empty |->
      (out_item.min_value == '0) && (out_item.max_value == '0))
    else $error("min/max not zero on empty stack");

  a_miss_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.found |-> (out_item.match_index == '0))
    else $error("match index set without a hit");

endmodule

bind stack_with_min_max_search_top smms_checker u_smms_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);
